>>> sv/mbsp_pkg.sv
// Shared types and constants for the MIDI byte stream parser.
// Used by the front, queue, back and checker modules; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mbsp_pkg;

  // result_kind codes on the output tuser
  localparam logic [1:0] KIND_MSG   = 2'd0;
  localparam logic [1:0] KIND_SYSEX = 2'd1;
  localparam logic [1:0] KIND_ERR   = 2'd2;

  // error_flags bits
  localparam logic [1:0] ERR_MSG = 2'b01;
  localparam logic [1:0] ERR_OVF = 2'b10;

  localparam logic [7:0] SX_ABORT = 8'hFF;

  localparam int unsigned OUT_TDATA_W = 40;

  // what closes the run of results caused by one byte
  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_MSG,
    TAIL_SYSEX,
    TAIL_ERR
  } tail_e;

  // one queued work record: up to four results, emitted in field order
  typedef struct packed {
    logic       ovf;     // overflow error first
    logic       abrt;    // sysex abort byte
    logic       err;     // message error
    tail_e      tail;
    logic [7:0] status;
    logic [6:0] data1;
    logic [6:0] data2;
    logic [1:0] len;
    logic [7:0] sx;
  } rec_t;

  // pending-result mask, bit 0 goes out first
  function automatic logic [3:0] rec_mask(rec_t r);
    rec_mask = {r.tail != TAIL_NONE, r.err, r.abrt, r.ovf};
  endfunction

endpackage

`default_nettype wire

>>> sv/midi_byte_stream_parser.sv
// An accepted byte is queued as a record, then its first result is registered
// in the output stage. Throughput: one byte per cycle while the record queue
// has room; the back end drains one result per cycle unless the output stalls,
// so a byte yields 1 to 4 results. Bytes that cause no result take no queue slot.
// Reset: queue and output stage empty, parser waits for the first status byte.
// Top level: instantiates mbsp_front, mbsp_fifo and mbsp_back; uses mbsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module midi_byte_stream_parser #(
  parameter int unsigned FifoDepth = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  wire logic        s_axis_tuser_i,   // [0] rx_overflow
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [1:0] error_flags, [9:2] msg_status, [16:10] msg_data_first,
  // [23:17] msg_data_second, [25:24] msg_length, [33:26] sysex_value, rest 0
  output logic [mbsp_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic [1:0]       m_axis_tuser_o,   // [1:0] result_kind
  output logic             m_axis_tlast_o
);

  logic           q_push, q_full, q_pop, q_valid;
  mbsp_pkg::rec_t q_rec, q_head;

  mbsp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_valid_i    (s_axis_tvalid_i),
    .rx_ready_o    (s_axis_tready_o),
    .rx_byte_i     (s_axis_tdata_i),
    .rx_overflow_i (s_axis_tuser_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_rec_o       (q_rec)
  );

  mbsp_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_rec_i (q_rec),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  mbsp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_kind_o  (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

>>> sv/mbsp_front.sv
// Front end: accepts received bytes, runs the running-status parse state
// and builds one work record per byte. Depends on mbsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbsp_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          rx_valid_i,
  output logic               rx_ready_o,
  input  wire logic [7:0]    rx_byte_i,
  input  wire logic          rx_overflow_i,
  input  wire logic          q_full_i,
  output logic               q_push_o,
  output mbsp_pkg::rec_t     q_rec_o
);

  localparam logic [3:0] M_INIT       = 4'd0;
  localparam logic [3:0] M_STATUS     = 4'd1;
  localparam logic [3:0] M_G3_FIRST   = 4'd2;
  localparam logic [3:0] M_G3_RUN     = 4'd3;
  localparam logic [3:0] M_G3_SECOND  = 4'd4;
  localparam logic [3:0] M_G2_FIRST   = 4'd5;
  localparam logic [3:0] M_G2_RUN     = 4'd6;
  localparam logic [3:0] M_SYSEX      = 4'd7;
  localparam logic [3:0] M_SC3_FIRST  = 4'd8;
  localparam logic [3:0] M_SC3_SECOND = 4'd9;
  localparam logic [3:0] M_SC2        = 4'd10;

  localparam logic [7:0] B_SX_START = 8'hF0;
  localparam logic [7:0] B_SX_END   = 8'hF7;
  localparam logic [7:0] B_SONG_POS = 8'hF2;
  localparam logic [7:0] B_MTC      = 8'hF1;
  localparam logic [7:0] B_SONG_SEL = 8'hF3;
  localparam logic [7:0] B_TUNE     = 8'hF6;
  localparam logic [7:0] B_RT_FIRST = 8'hF8;
  localparam logic [3:0] HI_PROG    = 4'hC;
  localparam logic [3:0] HI_PRESS   = 4'hD;
  localparam logic [3:0] HI_SYS     = 4'hF;

  logic [3:0] mode_q, mode_d;
  logic [7:0] status_q, status_d;
  logic [6:0] data1_q, data1_d;
  logic [6:0] data2_q, data2_d;
  logic [1:0] len_q, len_d;

  logic           accept;
  logic           is_st;
  logic           do_new;
  logic           emit_held;
  mbsp_pkg::rec_t rec;

  assign rx_ready_o = !q_full_i;
  assign accept     = rx_valid_i && !q_full_i;
  assign is_st      = rx_byte_i[7];

  always_comb begin
    mode_d    = mode_q;
    status_d  = status_q;
    data1_d   = data1_q;
    data2_d   = data2_q;
    len_d     = len_q;
    do_new    = 1'b0;
    emit_held = 1'b0;
    rec       = '0;
    rec.ovf   = rx_overflow_i;
    rec.tail  = mbsp_pkg::TAIL_NONE;

    if (rx_byte_i >= B_RT_FIRST) begin
      // realtime bypasses parse state
      rec.tail   = mbsp_pkg::TAIL_MSG;
      rec.status = rx_byte_i;
      rec.len    = 2'd1;
    end else begin
      case (mode_q)
        M_INIT: begin
          if (is_st && rx_byte_i != B_SX_END) do_new = 1'b1;
        end
        M_G3_FIRST, M_G3_RUN: begin
          if (is_st) begin
            rec.err = (mode_q == M_G3_FIRST);
            do_new  = 1'b1;
          end else begin
            data1_d = rx_byte_i[6:0];
            mode_d  = M_G3_SECOND;
          end
        end
        M_G3_SECOND: begin
          if (is_st) begin
            rec.err = 1'b1;
            do_new  = 1'b1;
          end else begin
            data2_d   = rx_byte_i[6:0];
            emit_held = 1'b1;
            mode_d    = M_G3_RUN;
          end
        end
        M_G2_FIRST, M_G2_RUN: begin
          if (is_st) begin
            rec.err = (mode_q == M_G2_FIRST);
            do_new  = 1'b1;
          end else begin
            data1_d   = rx_byte_i[6:0];
            emit_held = 1'b1;
            mode_d    = M_G2_RUN;
          end
        end
        M_SYSEX: begin
          if (!is_st) begin
            rec.tail = mbsp_pkg::TAIL_SYSEX;
            rec.sx   = rx_byte_i;
          end else if (rx_byte_i == B_SX_END) begin
            rec.tail = mbsp_pkg::TAIL_SYSEX;
            rec.sx   = B_SX_END;
            mode_d   = M_STATUS;
          end else begin
            rec.abrt = 1'b1;
            rec.err  = 1'b1;
            do_new   = 1'b1;
          end
        end
        M_SC3_FIRST: begin
          if (is_st) begin
            rec.err = 1'b1;
            do_new  = 1'b1;
          end else begin
            data1_d = rx_byte_i[6:0];
            mode_d  = M_SC3_SECOND;
          end
        end
        M_SC3_SECOND, M_SC2: begin
          if (is_st) begin
            rec.err = 1'b1;
            do_new  = 1'b1;
          end else begin
            if (mode_q == M_SC2) data1_d = rx_byte_i[6:0];
            else data2_d = rx_byte_i[6:0];
            emit_held = 1'b1;
            mode_d    = M_STATUS;
          end
        end
        default: begin
          if (is_st) do_new = 1'b1;
          else rec.err = 1'b1;
        end
      endcase

      if (do_new) begin
        status_d = rx_byte_i;
        case (rx_byte_i[7:4])
          HI_PROG, HI_PRESS: begin
            len_d  = 2'd2;
            mode_d = M_G2_FIRST;
          end
          HI_SYS: begin
            case (rx_byte_i)
              B_SX_START: begin
                rec.tail = mbsp_pkg::TAIL_SYSEX;
                rec.sx   = B_SX_START;
                mode_d   = M_SYSEX;
              end
              B_SONG_POS: begin
                len_d  = 2'd3;
                mode_d = M_SC3_FIRST;
              end
              B_MTC, B_SONG_SEL: begin
                len_d  = 2'd2;
                mode_d = M_SC2;
              end
              B_TUNE: begin
                len_d     = 2'd1;
                emit_held = 1'b1;
                mode_d    = M_STATUS;
              end
              default: begin
                // undefined or stray end of sysex
                rec.tail = mbsp_pkg::TAIL_ERR;
                mode_d   = M_STATUS;
              end
            endcase
          end
          default: begin
            len_d  = 2'd3;
            mode_d = M_G3_FIRST;
          end
        endcase
      end

      if (emit_held) begin
        rec.tail   = mbsp_pkg::TAIL_MSG;
        rec.status = status_d;
        rec.data1  = (len_d >= 2'd2) ? data1_d : 7'd0;
        rec.data2  = (len_d == 2'd3) ? data2_d : 7'd0;
        rec.len    = len_d;
      end
    end
  end

  assign q_rec_o  = rec;
  assign q_push_o = accept && (mbsp_pkg::rec_mask(rec) != 4'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_INIT;
      status_q <= '0;
      data1_q  <= '0;
      data2_q  <= '0;
      len_q    <= '0;
    end else if (accept) begin
      mode_q   <= mode_d;
      status_q <= status_d;
      data1_q  <= data1_d;
      data2_q  <= data2_d;
      len_q    <= len_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/mbsp_fifo.sv
// Short queue of work records between the parser front and the result back.
// Depends on mbsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbsp_fifo #(
  parameter int unsigned Depth = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire mbsp_pkg::rec_t push_rec_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output mbsp_pkg::rec_t     head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  mbsp_pkg::rec_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      if (do_pop) rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

>>> sv/mbsp_back.sv
// Back end: expands queued work records into result beats, one per cycle
// unless the output stalls, through a registered output stage. Depends on mbsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbsp_back (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               q_valid_i,
  input  wire mbsp_pkg::rec_t                     q_head_i,
  output logic                                    q_pop_o,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [mbsp_pkg::OUT_TDATA_W-1:0]        out_data_o,
  output logic [1:0]                              out_kind_o,
  output logic                                    out_last_o
);

  mbsp_pkg::rec_t hold_q, hold_d, src;
  logic [3:0] pend_q, pend_d;
  logic [3:0] src_mask, sel, rem;
  logic       use_hold, adv, fire;

  logic       out_valid_q, out_valid_d;
  logic [mbsp_pkg::OUT_TDATA_W-1:0] out_data_q, out_data_d;
  logic [1:0] out_kind_q, out_kind_d;
  logic       out_last_q, out_last_d;

  logic [1:0] r_flags;
  logic [7:0] r_status, r_sx;
  logic [6:0] r_d1, r_d2;
  logic [1:0] r_len, r_kind;

  always_comb begin
    use_hold = (pend_q != 4'd0);
    src      = use_hold ? hold_q : q_head_i;
    src_mask = use_hold ? pend_q :
               (q_valid_i ? mbsp_pkg::rec_mask(q_head_i) : 4'd0);
    sel      = src_mask & (~src_mask + 4'd1);
    rem      = src_mask & ~sel;
    adv      = !out_valid_q || out_ready_i;
    fire     = adv && (src_mask != 4'd0);
    q_pop_o  = fire && !use_hold;

    pend_d = pend_q;
    hold_d = hold_q;
    if (fire) begin
      pend_d = rem;
      if (!use_hold) hold_d = q_head_i;
    end

    r_kind   = mbsp_pkg::KIND_ERR;
    r_flags  = 2'd0;
    r_status = 8'd0;
    r_d1     = 7'd0;
    r_d2     = 7'd0;
    r_len    = 2'd0;
    r_sx     = 8'd0;
    if (sel[0]) begin
      r_flags = mbsp_pkg::ERR_OVF;
    end else if (sel[1]) begin
      r_kind = mbsp_pkg::KIND_SYSEX;
      r_sx   = mbsp_pkg::SX_ABORT;
    end else if (sel[2]) begin
      r_flags = mbsp_pkg::ERR_MSG;
    end else begin
      case (src.tail)
        mbsp_pkg::TAIL_MSG: begin
          r_kind   = mbsp_pkg::KIND_MSG;
          r_status = src.status;
          r_d1     = src.data1;
          r_d2     = src.data2;
          r_len    = src.len;
        end
        mbsp_pkg::TAIL_SYSEX: begin
          r_kind = mbsp_pkg::KIND_SYSEX;
          r_sx   = src.sx;
        end
        default: r_flags = mbsp_pkg::ERR_MSG;
      endcase
    end

    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_kind_d  = out_kind_q;
    out_last_d  = out_last_q;
    if (adv) begin
      out_valid_d = (src_mask != 4'd0);
      out_data_d  = {6'd0, r_sx, r_len, r_d2, r_d1, r_status, r_flags};
      out_kind_d  = r_kind;
      out_last_d  = (rem == 4'd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q     <= hold_d;
    out_data_q <= out_data_d;
    out_kind_q <= out_kind_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_kind_o  = out_kind_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

>>> sv/mbsp_checker.sv
// Port-level checks on the result stream of midi_byte_stream_parser,
// bound to the top level. Depends on mbsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbsp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [mbsp_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input wire logic [1:0]  m_axis_tuser_o,
  input wire logic        m_axis_tlast_o
);

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o &&
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("result beat changed while stalled");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tuser_o == mbsp_pkg::KIND_MSG ||
      m_axis_tuser_o == mbsp_pkg::KIND_SYSEX || m_axis_tuser_o == mbsp_pkg::KIND_ERR)
    else $error("undefined result kind");

  // errors carry flags and no message length
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == mbsp_pkg::KIND_ERR |->
      m_axis_tdata_o[1:0] != 2'd0 && m_axis_tdata_o[25:24] == 2'd0)
    else $error("error beat malformed");

  // messages carry a length and a status byte, never error flags
  a_msg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == mbsp_pkg::KIND_MSG |->
      m_axis_tdata_o[25:24] != 2'd0 && m_axis_tdata_o[9] && m_axis_tdata_o[1:0] == 2'd0)
    else $error("message beat malformed");

endmodule

bind midi_byte_stream_parser mbsp_checker u_mbsp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire
